[hdl/mifp_pkg.sv]
// package for the meter information frame parser
// byte classes, event and error codes, field capacities, queue entry type
// no dependencies
package mifp_pkg;

   // control bytes of the serial stream
   localparam logic [7:0] BYTE_STX = 8'h02;
   localparam logic [7:0] BYTE_ETX = 8'h03;
   localparam logic [7:0] BYTE_LF  = 8'h0A;
   localparam logic [7:0] BYTE_CR  = 8'h0D;
   localparam logic [7:0] SEP_HISTORIC = 8'h20;
   localparam logic [7:0] SEP_STANDARD = 8'h09;

   // check character offset and sum mask width
   localparam int SUM_W = 6;
   localparam logic [6:0] CHECK_OFFSET = 7'h20;

   // field capacities and dataset limit
   localparam logic [4:0] LABEL_CAP  = 5'd16;
   localparam logic [4:0] SECOND_CAP = 5'd16;
   localparam logic [4:0] THIRD_CAP  = 5'd16;
   localparam logic [4:0] FOURTH_CAP = 5'd4;
   localparam logic [6:0] MAX_SETS   = 7'd64;

   // transaction queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      CLS_STX,
      CLS_ETX,
      CLS_LF,
      CLS_CR,
      CLS_SEP,
      CLS_DATA
   } byte_class_type;

   typedef enum logic [2:0] {
      EV_IGNORED       = 3'd0,
      EV_FRAME_START   = 3'd1,
      EV_CHAR_STORED   = 3'd2,
      EV_SEPARATOR     = 3'd3,
      EV_DATASET_START = 3'd4,
      EV_DATASET_OK    = 3'd5,
      EV_FRAME_END     = 3'd6,
      EV_ERROR         = 3'd7
   } event_type;

   typedef enum logic [2:0] {
      ERR_NONE           = 3'd0,
      ERR_START_IN_FRAME = 3'd1,
      ERR_TOO_MANY_SETS  = 3'd2,
      ERR_FIELD_FULL     = 3'd3,
      ERR_TOO_MANY_FLDS  = 3'd4,
      ERR_CHECKSUM       = 3'd5,
      ERR_NO_LINE_START  = 3'd6
   } error_type;

   typedef struct packed {
      byte_class_type cls;
      logic [7:0]     rx_byte;
   } queue_entry_type;

   // capacity of each field
   function automatic logic [4:0] field_cap(input logic [1:0] idx);
      logic [4:0] cap;
      unique case (idx)
         2'd0:    cap = LABEL_CAP;
         2'd1:    cap = SECOND_CAP;
         2'd2:    cap = THIRD_CAP;
         default: cap = FOURTH_CAP;
      endcase
      return cap;
   endfunction

endpackage

[hdl/meter_info_frame_parser.sv]
// top level of the meter information frame parser
// depends on mifp_pkg, mifp_front, mifp_queue, mifp_back
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_rx_byte
//   rsp      out        rsp_valid/rsp_stall  rsp_event_res .. rsp_has_timestamp
//   csr      in         csr_wr_en            csr_wr_data (standard_mode)
//
// one result per byte; a byte enters every cycle while the queue is not full and
// is classified by the front into a two-entry queue, then the back state update
// writes its result into the result register; the back end's state update sets the rate
// reset is synchronous and active high; it clears frame state and the mode bit
// a stalled result holds the result register; the queue absorbs input until full
module meter_info_frame_parser import mifp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_event_res,
   output logic [7:0] rsp_byte_echo,
   output logic [1:0] rsp_field_index,
   output logic [2:0] rsp_error_code,
   output logic [6:0] rsp_dataset_total,
   output logic [6:0] rsp_check_computed,
   output logic       rsp_has_timestamp,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic            mode_ff, mode_in;
   logic            push;
   logic            pop;
   logic            queue_full;
   logic            queue_not_empty;
   queue_entry_type push_entry;
   queue_entry_type head;

   // mode register
   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   mifp_front u_front (
      .standard_mode (mode_ff),
      .req_valid     (req_valid),
      .req_rx_byte   (req_rx_byte),
      .queue_full    (queue_full),
      .req_stall     (req_stall),
      .push          (push),
      .push_entry    (push_entry)
   );

   mifp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   mifp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .standard_mode      (mode_ff),
      .queue_not_empty    (queue_not_empty),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_res      (rsp_event_res),
      .rsp_byte_echo      (rsp_byte_echo),
      .rsp_field_index    (rsp_field_index),
      .rsp_error_code     (rsp_error_code),
      .rsp_dataset_total  (rsp_dataset_total),
      .rsp_check_computed (rsp_check_computed),
      .rsp_has_timestamp  (rsp_has_timestamp)
   );

endmodule

[hdl/mifp_front.sv]
// front end of the frame parser: accepts bytes and classifies them
// depends on mifp_pkg
module mifp_front import mifp_pkg::*; (
   input  logic            standard_mode,
   input  logic            req_valid,
   input  logic [7:0]      req_rx_byte,
   input  logic            queue_full,
   output logic            req_stall,
   output logic            push,
   output queue_entry_type push_entry
);

   logic [7:0] sep_byte;

   // separator follows the line protocol mode
   assign sep_byte = standard_mode ? SEP_STANDARD : SEP_HISTORIC;

   // byte classification
   always_comb begin
      push_entry.rx_byte = req_rx_byte;
      if (req_rx_byte == BYTE_STX) begin
         push_entry.cls = CLS_STX;
      end else if (req_rx_byte == BYTE_ETX) begin
         push_entry.cls = CLS_ETX;
      end else if (req_rx_byte == BYTE_LF) begin
         push_entry.cls = CLS_LF;
      end else if (req_rx_byte == BYTE_CR) begin
         push_entry.cls = CLS_CR;
      end else if (req_rx_byte == sep_byte) begin
         push_entry.cls = CLS_SEP;
      end else begin
         push_entry.cls = CLS_DATA;
      end
   end

   // handshake toward the queue
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

endmodule

[hdl/mifp_queue.sv]
// short transaction queue between the front and back of the frame parser
// depends on mifp_pkg
module mifp_queue import mifp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   input  logic            pop,
   output logic            full,
   output logic            not_empty,
   output queue_entry_type head
);

   queue_entry_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[hdl/mifp_back.sv]
// back end of the frame parser: frame and field state, checksum, result register
// depends on mifp_pkg
module mifp_back import mifp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            standard_mode,
   input  logic            queue_not_empty,
   input  queue_entry_type head,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [2:0]      rsp_event_res,
   output logic [7:0]      rsp_byte_echo,
   output logic [1:0]      rsp_field_index,
   output logic [2:0]      rsp_error_code,
   output logic [6:0]      rsp_dataset_total,
   output logic [6:0]      rsp_check_computed,
   output logic            rsp_has_timestamp
);

   // parser state
   logic             in_frame_ff, in_frame_in;
   logic             sel_valid_ff, sel_valid_in;
   logic [1:0]       sel_ff, sel_in;
   logic [4:0]       len_ff [4];
   logic [4:0]       len_in [4];
   logic [SUM_W-1:0] sum_ff [3];
   logic [SUM_W-1:0] sum_in [3];
   logic [7:0]       first3_ff, first3_in;
   logic [7:0]       first4_ff, first4_in;
   logic [6:0]       count_ff, count_in;

   // result register
   logic             valid_ff, valid_in;
   event_type        event_ff, event_in;
   logic [7:0]       byte_ff;
   logic [1:0]       fidx_ff, fidx_in;
   error_type        err_ff, err_in;
   logic [6:0]       total_ff, total_in;
   logic [6:0]       chk_ff, chk_in;
   logic             ts_ff, ts_in;

   logic [SUM_W-1:0] sep_sum;
   logic [SUM_W-1:0] line_sum;
   logic [7:0]       want;
   logic [4:0]       cur_len;
   logic             fail;
   logic             to_idle;

   assign sep_sum = standard_mode ? SEP_STANDARD[SUM_W-1:0] : SEP_HISTORIC[SUM_W-1:0];
   assign cur_len = len_ff[sel_ff];

   // take the next transaction when the result register is free or draining
   assign pop = queue_not_empty && (!valid_ff || !rsp_stall);

   // line checksum, mod 64 by width
   always_comb begin
      line_sum = sum_ff[0] + sep_sum + sum_ff[1];
      if (len_ff[3] != '0) begin
         line_sum = line_sum + sep_sum + sum_ff[2];
      end
      if (standard_mode) begin
         line_sum = line_sum + sep_sum;
      end
      want = (len_ff[3] != '0) ? first4_ff : first3_ff;
   end

   // per-byte state update
   always_comb begin
      in_frame_in  = in_frame_ff;
      sel_valid_in = sel_valid_ff;
      sel_in       = sel_ff;
      len_in       = len_ff;
      sum_in       = sum_ff;
      first3_in    = first3_ff;
      first4_in    = first4_ff;
      count_in     = count_ff;
      event_in     = EV_IGNORED;
      fidx_in      = '0;
      err_in       = ERR_NONE;
      chk_in       = '0;
      ts_in        = 1'b0;
      fail         = 1'b0;
      to_idle      = 1'b0;

      if (!in_frame_ff) begin
         if (head.cls == CLS_STX) begin
            in_frame_in = 1'b1;
            event_in    = EV_FRAME_START;
         end
      end else begin
         case (head.cls)
            CLS_STX: begin
               err_in = ERR_START_IN_FRAME;
               fail   = 1'b1;
            end
            CLS_ETX: begin
               event_in = EV_FRAME_END;
               to_idle  = 1'b1;
            end
            CLS_LF: begin
               if (count_ff >= MAX_SETS) begin
                  err_in = ERR_TOO_MANY_SETS;
                  fail   = 1'b1;
               end else begin
                  for (int i = 0; i < 4; i++) len_in[i] = '0;
                  for (int i = 0; i < 3; i++) sum_in[i] = '0;
                  first3_in    = '0;
                  first4_in    = '0;
                  sel_valid_in = 1'b1;
                  sel_in       = '0;
                  event_in     = EV_DATASET_START;
               end
            end
            CLS_CR: begin
               ts_in  = (len_ff[3] != '0);
               chk_in = {1'b0, line_sum} + CHECK_OFFSET;
               if ({1'b0, chk_in} != want) begin
                  err_in = ERR_CHECKSUM;
                  fail   = 1'b1;
               end else if (count_ff >= MAX_SETS) begin
                  err_in = ERR_TOO_MANY_SETS;
                  fail   = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
                  event_in = EV_DATASET_OK;
               end
            end
            default: begin
               // separator or data byte
               if (!sel_valid_ff) begin
                  err_in = ERR_NO_LINE_START;
                  fail   = 1'b1;
               end else begin
                  fidx_in = sel_ff;
                  if (head.cls == CLS_SEP && cur_len != '0) begin
                     if (sel_ff == 2'd3) begin
                        err_in = ERR_TOO_MANY_FLDS;
                        fail   = 1'b1;
                     end else begin
                        sel_in   = sel_ff + 1'b1;
                        event_in = EV_SEPARATOR;
                     end
                  end else if (cur_len >= field_cap(sel_ff)) begin
                     err_in = ERR_FIELD_FULL;
                     fail   = 1'b1;
                  end else begin
                     // a zero byte is reported but leaves the field untouched
                     if (head.rx_byte != '0) begin
                        for (int i = 0; i < 3; i++) begin
                           if (sel_ff == 2'(i)) begin
                              sum_in[i] = sum_ff[i] + head.rx_byte[SUM_W-1:0];
                           end
                        end
                        if (cur_len == '0 && sel_ff == 2'd2) first3_in = head.rx_byte;
                        if (cur_len == '0 && sel_ff == 2'd3) first4_in = head.rx_byte;
                        len_in[sel_ff] = cur_len + 1'b1;
                     end
                     event_in = EV_CHAR_STORED;
                  end
               end
            end
         endcase
      end

      // count reported before any clearing
      total_in = count_in;

      if (fail) begin
         event_in = EV_ERROR;
         fidx_in  = '0;
         to_idle  = 1'b1;
      end
      if (to_idle) begin
         in_frame_in  = 1'b0;
         sel_valid_in = 1'b0;
         sel_in       = '0;
         count_in     = '0;
         for (int i = 0; i < 4; i++) len_in[i] = '0;
         for (int i = 0; i < 3; i++) sum_in[i] = '0;
         first3_in = '0;
         first4_in = '0;
      end
   end

   // result valid follows pops and downstream takes
   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         sel_valid_ff <= 1'b0;
         sel_ff       <= '0;
         count_ff     <= '0;
         first3_ff    <= '0;
         first4_ff    <= '0;
         for (int i = 0; i < 4; i++) len_ff[i] <= '0;
         for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
         valid_ff     <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            in_frame_ff  <= in_frame_in;
            sel_valid_ff <= sel_valid_in;
            sel_ff       <= sel_in;
            count_ff     <= count_in;
            first3_ff    <= first3_in;
            first4_ff    <= first4_in;
            len_ff       <= len_in;
            sum_ff       <= sum_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         event_ff <= event_in;
         byte_ff  <= head.rx_byte;
         fidx_ff  <= fidx_in;
         err_ff   <= err_in;
         total_ff <= total_in;
         chk_ff   <= chk_in;
         ts_ff    <= ts_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_event_res      = event_ff;
   assign rsp_byte_echo      = byte_ff;
   assign rsp_field_index    = fidx_ff;
   assign rsp_error_code     = err_ff;
   assign rsp_dataset_total  = total_ff;
   assign rsp_check_computed = chk_ff;
   assign rsp_has_timestamp  = ts_ff;

   // dataset count never passes the limit
   assert property (@(posedge clock) disable iff (reset) count_ff <= MAX_SETS)
      else $error("dataset count beyond limit");

   // outside a frame no field is active and the count is clear
   assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (!sel_valid_ff && count_ff == '0))
      else $error("field state live outside a frame");

   // an error result always carries a code, other results none
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ((event_ff == EV_ERROR) == (err_ff != ERR_NONE)))
      else $error("error code does not match event");

   // a frame start leaves the block inside a frame
   assert property (@(posedge clock) disable iff (reset)
      (pop && event_in == EV_FRAME_START) |=> in_frame_ff)
      else $error("frame start not taken");

endmodule
